// ----- rtl/ptu_pkg.sv -----
// Shared types, widths and color helpers for the paletted texture unswizzle block.
// Used by paletted_texture_unswizzle and ptu_checker; depends on nothing.

package ptu_pkg;

   // field widths
   localparam int DIM_W       = 13;
   localparam int COUNT_W     = 24;
   localparam int SLOT_W      = 8;
   localparam int WORD_W      = 32;
   localparam int COORD_W     = 12;
   localparam int TOTAL_W     = 2 * DIM_W;
   localparam int MODE_W      = 3;

   // port widths
   localparam int REQ_DATA_W  = 48;   // slot + word + code
   localparam int RSP_DATA_W  = 64;   // rgba + x + y + in_bounds, padded
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = DIM_W;

   // parameter defaults
   localparam int PALETTE_DEPTH_DEF = 256;
   localparam int MAX_DIMENSION_DEF = 4096;

   // largest dimension the register can hold
   localparam int DIM_MAX = (1 << DIM_W) - 1;

   // divider runs one quotient bit per cycle
   localparam int DIV_STEPS = COUNT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_ORDER = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MORTON_ORDER  = 2'd3;

   localparam logic OP_PALETTE_WRITE = 1'b0;
   localparam logic OP_PIXEL         = 1'b1;

   localparam logic [MODE_W-1:0] CO_ABGR = 3'd0;
   localparam logic [MODE_W-1:0] CO_ARGB = 3'd1;
   localparam logic [MODE_W-1:0] CO_RGBA = 3'd2;
   localparam logic [MODE_W-1:0] CO_BGRA = 3'd3;
   localparam logic [MODE_W-1:0] CO_XBGR = 3'd4;
   localparam logic [MODE_W-1:0] CO_XRGB = 3'd5;
   localparam logic [MODE_W-1:0] CO_RGBX = 3'd6;
   localparam logic [MODE_W-1:0] CO_BGRX = 3'd7;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // byte-reverse the palette word, then reorder channels; R ends in the low byte
   function automatic logic [WORD_W-1:0] convert_color(
      input logic [WORD_W-1:0] word,
      input logic [MODE_W-1:0] mode
   );
      logic [7:0] s0, s1, s2, s3;
      logic [WORD_W-1:0] res;
      s0 = word[31:24];
      s1 = word[23:16];
      s2 = word[15:8];
      s3 = word[7:0];
      unique case (mode)
         CO_ABGR: res = {s0, s1, s2, s3};
         CO_ARGB: res = {s0, s3, s2, s1};
         CO_RGBA: res = {s3, s2, s1, s0};
         CO_BGRA: res = {s3, s0, s1, s2};
         CO_XBGR: res = {ALPHA_OPAQUE, s1, s2, s3};
         CO_XRGB: res = {ALPHA_OPAQUE, s3, s2, s1};
         CO_RGBX: res = {ALPHA_OPAQUE, s2, s1, s0};
         CO_BGRX: res = {ALPHA_OPAQUE, s0, s1, s2};
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

// ----- rtl/paletted_texture_unswizzle.sv -----
// A pixel item takes a palette read and address setup, 24 steps of the shared restoring
// divider and a finish step, which waits while rsp holds an untaken result. The 24-bit
// divider yields one quotient bit per cycle; no item is taken until a pixel item is done,
// but palette writes go back to back while idle. Reset (synchronous): sequencer, output valid,
// pixel counter, config registers return to defaults; palette contents are not cleared.
// Depends on ptu_pkg.

module paletted_texture_unswizzle #(
   parameter int PALETTE_DEPTH = ptu_pkg::PALETTE_DEPTH_DEF,
   parameter int MAX_DIMENSION = ptu_pkg::MAX_DIMENSION_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: tdata = palette_slot[7:0], palette_word[39:8], pixel_code[47:40]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ptu_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,   // op
   // response: tdata = pixel_rgba[31:0], dest_x[43:32], dest_y[55:44], in_bounds[56]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ptu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,   // last_pixel
   // configuration
   input  logic                            csr_we,
   input  logic [ptu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ptu_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ptu_pkg::*;

   localparam int PAL_AW = $clog2(PALETTE_DEPTH);
   localparam logic [DIM_W-1:0] DIM_CAP =
      DIM_W'((MAX_DIMENSION > DIM_MAX) ? DIM_MAX : MAX_DIMENSION);
   localparam logic [SLOT_W:0] PAL_LIMIT = (SLOT_W+1)'(PALETTE_DEPTH);

   // request fields
   logic [SLOT_W-1:0] req_slot;
   logic [WORD_W-1:0] req_word;
   logic [SLOT_W-1:0] req_code;
   assign req_slot = req_tdata[7:0];
   assign req_word = req_tdata[39:8];
   assign req_code = req_tdata[47:40];

   // configuration registers
   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [MODE_W-1:0] order_ff;
   logic              morton_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(4);
         height_ff <= DIM_W'(1);
         order_ff  <= CO_ABGR;
         morton_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT:  height_ff <= csr_wdata;
            CSR_CHANNEL_ORDER: order_ff  <= csr_wdata[MODE_W-1:0];
            CSR_MORTON_ORDER:  morton_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [DIM_W-1:0] w_clamp, h_clamp;
   assign w_clamp = (width_ff  > DIM_CAP) ? DIM_CAP : width_ff;
   assign h_clamp = (height_ff > DIM_CAP) ? DIM_CAP : height_ff;

   // sequencer and datapath registers
   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 code_ok_ff, code_ok_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic                 swap_ff, swap_in;
   logic [DIM_W-1:0]     div_ff, div_in;
   logic [DIM_W-1:0]     rem_ff, rem_in;
   logic [COUNT_W-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   // palette memory, registered read
   logic [WORD_W-1:0] pal_mem [PALETTE_DEPTH];
   logic [WORD_W-1:0] pal_word_ff;
   logic              req_take;

   assign req_take = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (req_take && req_tuser == OP_PALETTE_WRITE && {1'b0, req_slot} < PAL_LIMIT) begin
         pal_mem[req_slot[PAL_AW-1:0]] <= req_word;
      end
      if (req_take) begin
         pal_word_ff <= pal_mem[req_code[PAL_AW-1:0]];
      end
   end

   // Morton de-interleave terms
   logic [DIM_W-1:0]     mn, mn_m1;
   logic [3:0]           lg;
   logic [4:0]           sh2;
   logic [COORD_W-1:0]   ev_x, ev_y, mx, my;
   logic [COUNT_W-1:0]   j_addr;

   always_comb begin
      mn = (w_clamp < h_clamp) ? w_clamp : h_clamp;
      mn_m1 = mn - DIM_W'(1);
      lg = '0;
      for (int b = 0; b < DIM_W; b++) begin
         if (mn[b]) lg = 4'(b);
      end
      sh2 = {lg, 1'b0};
      for (int n = 0; n < COORD_W; n++) begin
         ev_x[n] = count_ff[2*n];
         ev_y[n] = count_ff[2*n+1];
      end
      mx = ev_x & mn_m1[COORD_W-1:0];
      my = ev_y & mn_m1[COORD_W-1:0];
      j_addr = (count_ff >> sh2) << sh2;
      if (h_clamp < w_clamp) begin
         j_addr = j_addr | (COUNT_W'(my) << lg) | COUNT_W'(mx);
      end else begin
         j_addr = j_addr | (COUNT_W'(mx) << lg) | COUNT_W'(my);
      end
   end

   // shared divider step
   logic [DIM_W:0]   div_shift, div_diff;
   logic             div_ge;
   assign div_shift = {rem_ff, quo_ff[COUNT_W-1]};
   assign div_diff  = div_shift - {1'b0, div_ff};
   assign div_ge    = div_shift >= {1'b0, div_ff};

   // finish terms
   logic [COUNT_W-1:0] x_full, y_full;
   logic               empty_img, in_img, last;
   logic [WORD_W-1:0]  color;

   always_comb begin
      x_full = swap_ff ? quo_ff : COUNT_W'(rem_ff);
      y_full = swap_ff ? COUNT_W'(rem_ff) : quo_ff;
      empty_img = (total_ff == '0);
      in_img = !empty_img && x_full < COUNT_W'(w_clamp) && y_full < COUNT_W'(h_clamp);
      last = empty_img || (TOTAL_W'(count_ff) + TOTAL_W'(1) >= total_ff);
      if (empty_img) begin
         x_full = '0;
         y_full = '0;
      end
      color = convert_color(code_ok_ff ? pal_word_ff : '0, order_ff);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      code_ok_in   = code_ok_ff;
      total_in     = total_ff;
      swap_in      = swap_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && req_tuser == OP_PIXEL) begin
               code_ok_in = {1'b0, req_code} < PAL_LIMIT;
               state_in   = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            total_in = TOTAL_W'(w_clamp) * TOTAL_W'(h_clamp);
            swap_in  = morton_ff && (h_clamp < w_clamp);
            div_in   = (morton_ff && h_clamp < w_clamp) ? h_clamp : w_clamp;
            quo_in   = morton_ff ? j_addr : count_ff;
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in  = div_ge ? div_diff[DIM_W-1:0] : div_shift[DIM_W-1:0];
            quo_in  = {quo_ff[COUNT_W-2:0], div_ge};
            step_in = step_ff + DIV_CNT_W'(1);
            if (step_ff == DIV_CNT_W'(DIV_STEPS - 1)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, in_img, y_full[COORD_W-1:0], x_full[COORD_W-1:0], color};
               rsp_last_in  = last;
               count_in     = last ? '0 : count_ff + COUNT_W'(1);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ok_ff  <= code_ok_in;
      total_ff    <= total_in;
      swap_ff     <= swap_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/ptu_checker.sv -----
// Port-level checks for paletted_texture_unswizzle, bound to the top level.
// Depends on ptu_pkg.

module ptu_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ptu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tlast
);
   import ptu_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // leaving reset: idle, ready, nothing pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

   // a pixel item occupies the sequencer
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_PIXEL |=> !req_tready)
      else $error("ready right after a pixel item");

   // a new result only comes out of a busy cycle
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result without pixel work");

endmodule

bind paletted_texture_unswizzle ptu_checker u_ptu_checker (.*);

// ----- test/paletted_texture_unswizzle_tb.sv -----
// Self-checking testbench for paletted_texture_unswizzle: palette loads, channel reorder,
// linear and Morton placement, frame wrap, with random idling on both stream sides.
// Depends on ptu_pkg and the block RTL.
`timescale 1ns / 1ps

module paletted_texture_unswizzle_tb;
   import ptu_pkg::*;

   localparam int DRAIN_CYCLES   = 32;     // longer than a pixel item takes to reach rsp
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [WORD_W-1:0]  rgba;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               in_image;
      logic               last;
   } pixel_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;   // palette_slot, palette_word, pixel_code
   logic                   req_tuser = 1'b0; // op
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;        // pixel_rgba, dest_x, dest_y, in_bounds
   logic                   rsp_tlast;        // last_pixel
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predictor state
   logic [WORD_W-1:0]  palette_copy [256];
   bit                 slot_known [256];
   logic [SLOT_W-1:0]  known_slots [$];
   logic [COUNT_W-1:0] pixel_count = '0;
   int unsigned        img_width = 4;
   int unsigned        img_height = 1;
   logic [MODE_W-1:0]  chan_mode = CO_ABGR;
   logic               morton_on = 1'b0;

   pixel_result_type pending_pixels [$];
   int            bad_fields = 0;
   int            idle_cycles = 0;
   bit            steady = 1'b0;

   paletted_texture_unswizzle dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 33);
   end

   // gather the even bits of v into the low half
   function automatic int unsigned even_bits(input int unsigned v);
      int unsigned res;
      res = 0;
      for (int b = 0; b < 16; b++)
         res[b] = v[2 * b];
      return res;
   endfunction

   function automatic int unsigned log2_floor(input int unsigned v);
      int unsigned n;
      n = 0;
      while (v > 1) begin
         v = v >> 1;
         n++;
      end
      return n;
   endfunction

   function automatic logic [WORD_W-1:0] reorder_color(input logic [WORD_W-1:0] word,
                                                       input logic [MODE_W-1:0] mode);
      logic [7:0] rev [4];
      logic [7:0] red, green, blue, alpha;
      // byte-reversed view: rev[0] is the top byte of the palette word
      rev[0] = word[31:24];
      rev[1] = word[23:16];
      rev[2] = word[15:8];
      rev[3] = word[7:0];
      case (mode)
         CO_ABGR, CO_XBGR: begin
            red = rev[3]; green = rev[2]; blue = rev[1]; alpha = rev[0];
         end
         CO_ARGB, CO_XRGB: begin
            red = rev[1]; green = rev[2]; blue = rev[3]; alpha = rev[0];
         end
         CO_RGBA, CO_RGBX: begin
            red = rev[0]; green = rev[1]; blue = rev[2]; alpha = rev[3];
         end
         default: begin
            red = rev[2]; green = rev[1]; blue = rev[0]; alpha = rev[3];
         end
      endcase
      if (mode inside {CO_XBGR, CO_XRGB, CO_RGBX, CO_BGRX})
         alpha = ALPHA_OPAQUE;
      return {alpha, blue, green, red};
   endfunction

   function automatic void decode_pixel(input logic [SLOT_W-1:0] code);
      int unsigned     w, h, pos, side, k, mx, my, blk, x, y;
      longint unsigned area;
      pixel_result_type res;
      w = (img_width > MAX_DIMENSION_DEF) ? MAX_DIMENSION_DEF : img_width;
      h = (img_height > MAX_DIMENSION_DEF) ? MAX_DIMENSION_DEF : img_height;
      pos = 32'(pixel_count);
      area = longint'(w) * longint'(h);
      x = 0;
      y = 0;
      res.rgba = reorder_color(palette_copy[code], chan_mode);
      if (area == 0) begin
         res.in_image = 1'b0;
         res.last = 1'b1;
      end else begin
         if (morton_on) begin
            // square of side min(w, h) is de-interleaved, higher bits count squares
            side = (w < h) ? w : h;
            k = log2_floor(side);
            mx = even_bits(pos) & (side - 1);
            my = even_bits(pos >> 1) & (side - 1);
            blk = (pos >> (2 * k)) << (2 * k);
            if (h < w) begin
               blk = blk | (my << k) | mx;
               x = blk / h;
               y = blk % h;
            end else begin
               blk = blk | (mx << k) | my;
               x = blk % w;
               y = blk / w;
            end
         end else begin
            x = pos % w;
            y = pos / w;
         end
         res.in_image = (x < w) && (y < h);
         res.last = (longint'(pos) >= area - 1);
      end
      res.col = x[COORD_W-1:0];
      res.row = y[COORD_W-1:0];
      pixel_count = res.last ? '0 : pixel_count + 1'b1;
      pending_pixels.push_back(res);
   endfunction

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         bad_fields++;
         if (bad_fields <= 10)
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
      end
   endfunction

   // outputs are stable from the falling edge to the next rising edge
   always @(negedge clock) begin
      pixel_result_type want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               bad_fields++;
               if (bad_fields <= 10)
                  $display("%0t: unexpected pixel %h", $time, rsp_tdata);
            end else begin
               want = pending_pixels.pop_front();
               check_field("pixel_rgba", want.rgba, rsp_tdata[31:0]);
               check_field("dest_x", 32'(want.col), 32'(rsp_tdata[43:32]));
               check_field("dest_y", 32'(want.row), 32'(rsp_tdata[55:44]));
               check_field("in_bounds", 32'(want.in_image), 32'(rsp_tdata[56]));
               check_field("last_pixel", 32'(want.last), 32'(rsp_tlast));
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot,
                            input logic [WORD_W-1:0] word, input logic [SLOT_W-1:0] code);
      while (!steady && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {code, word, slot};
      do @(negedge clock); while (!req_tready);
      // accepted at the coming rising edge
      if (op == OP_PIXEL) begin
         decode_pixel(code);
      end else begin
         palette_copy[slot] = word;
         if (!slot_known[slot]) begin
            slot_known[slot] = 1'b1;
            known_slots.push_back(slot);
         end
      end
      @(posedge clock);
   endtask

   task automatic wait_quiet(input int extra);
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (idx)
         CSR_IMAGE_WIDTH:   img_width = value & DIM_MAX;
         CSR_IMAGE_HEIGHT:  img_height = value & DIM_MAX;
         CSR_CHANNEL_ORDER: chan_mode = value[MODE_W-1:0];
         default:           morton_on = value[0];
      endcase
      @(posedge clock);
   endtask

   task automatic set_image(input int unsigned w, input int unsigned h,
                            input logic [MODE_W-1:0] mode, input logic morton);
      wait_quiet(DRAIN_CYCLES);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_CHANNEL_ORDER, 32'(mode));
      write_reg(CSR_MORTON_ORDER, 32'(morton));
      csr_we <= 1'b0;
   endtask

   // only codes of slots already loaded are read
   function automatic logic [SLOT_W-1:0] pick_code();
      return known_slots[$urandom_range(known_slots.size() - 1)];
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      int unsigned r;
      r = $urandom_range(19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   function automatic int unsigned pick_dim(input bit across);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return across ? 4 * $urandom_range(1, 6) : $urandom_range(1, 12);
      if (r < 80) return 1 << $urandom_range(0, 5);
      if (r < 90) return $urandom_range(0, 63);
      if (r < 96) return $urandom_range(0, DIM_MAX);
      return r[0] ? MAX_DIMENSION_DEF : DIM_MAX;
   endfunction

   task automatic random_item();
      if ($urandom_range(99) < 65)
         send_item(OP_PIXEL, SLOT_W'($urandom_range(255)), $urandom, pick_code());
      else
         send_item(OP_PALETTE_WRITE, SLOT_W'($urandom_range(255)), pick_word(),
                   SLOT_W'($urandom_range(255)));
   endtask

   task automatic test_palette_and_modes();
      send_item(OP_PALETTE_WRITE, 8'h00, 32'h0000_0000, 8'hFF);
      send_item(OP_PALETTE_WRITE, 8'hFF, 32'hFFFF_FFFF, 8'h00);
      send_item(OP_PALETTE_WRITE, 8'h5A, 32'h1122_3344, 8'hA5);
      send_item(OP_PALETTE_WRITE, 8'hA5, 32'h80FF_017F, 8'h5A);
      send_item(OP_PIXEL, 8'h00, 32'h0, 8'h00);
      send_item(OP_PIXEL, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
      for (int m = CO_ABGR; m <= CO_BGRX; m++) begin
         set_image(4, 1, MODE_W'(m), 1'b0);
         send_item(OP_PIXEL, 8'h00, 32'h0, (m % 2) ? 8'hA5 : 8'h5A);
      end
   endtask

   task automatic test_geometry_corners();
      // empty image, zero width then zero height
      set_image(0, 5, CO_RGBA, 1'b0);
      send_item(OP_PIXEL, 8'h00, 32'h0, 8'h5A);
      set_image(4, 0, CO_RGBA, 1'b1);
      send_item(OP_PIXEL, 8'h00, 32'h0, 8'h5A);
      // oversize width saturates
      set_image(DIM_MAX, MAX_DIMENSION_DEF, CO_BGRX, 1'b1);
      send_item(OP_PIXEL, 8'h00, 32'h0, 8'hA5);
      // counter left past the end of a smaller image
      set_image(16, 16, CO_ARGB, 1'b0);
      repeat (4) send_item(OP_PIXEL, 8'h00, 32'h0, 8'h5A);
      set_image(4, 1, CO_ARGB, 1'b0);
      send_item(OP_PIXEL, 8'h00, 32'h0, 8'h5A);
      // non-power-of-two square side, width not a multiple of four
      set_image(6, 3, CO_XRGB, 1'b1);
      repeat (3) send_item(OP_PIXEL, 8'h00, 32'h0, 8'hA5);
      set_image(3, 8, CO_XBGR, 1'b1);
      send_item(OP_PIXEL, 8'h00, 32'h0, 8'hFF);
   endtask

   task automatic test_random_frames();
      int n;
      for (int round = 0; round < 20; round++) begin
         set_image(pick_dim(1'b1), pick_dim(1'b0), MODE_W'($urandom_range(7)),
                   1'($urandom_range(1)));
         n = $urandom_range(30, 80);
         for (int it = 0; it < n; it++) begin
            // now and then hold the sender until the block has drained
            if ($urandom_range(99) < 2)
               wait_quiet(0);
            random_item();
         end
      end
   endtask

   task automatic test_back_to_back();
      steady = 1'b1;
      set_image(8, 4, MODE_W'($urandom_range(7)), 1'b1);
      repeat (150) random_item();
      wait_quiet(0);
      steady = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_palette_and_modes();
      test_geometry_corners();
      test_random_frames();
      test_back_to_back();
      wait_quiet(DRAIN_CYCLES);
      if (bad_fields == 0 && pending_pixels.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/ptu_pkg.sv
rtl/paletted_texture_unswizzle.sv
rtl/ptu_checker.sv
test/paletted_texture_unswizzle_tb.sv
